// ----- rtl/bhrt_pkg.sv -----
// Shared constants, codes and types of the bucketed hash record table.
`default_nettype none

package bhrt_pkg;

   localparam int SLOTS     = 4;
   localparam int BUCKETS   = 99;
   localparam int KEY_BYTES = 11;
   localparam int KH_W      = 48;
   localparam int KL_W      = 40;
   localparam int KEY_W     = KH_W + KL_W;
   localparam int PAY_W     = 64;
   localparam int ACT_W     = 2;
   localparam int STAT_W    = 2;
   localparam int BKT_W     = $clog2(BUCKETS);
   localparam int DEPTH     = BUCKETS * SLOTS;
   localparam int ADDR_W    = $clog2(DEPTH);
   localparam int SLOT_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int SCNT_W    = $clog2(SLOTS + 1);
   localparam int ENTRY_W   = KEY_W + PAY_W;

   // Folding hash: pairs of padded bytes, running sum kept below FOLD_MOD.
   localparam int FOLD_MUL  = 100;
   localparam int FOLD_MOD  = 20000;
   localparam int PAIRS     = (KEY_BYTES + 1) / 2;
   localparam int SUM_W     = 15;
   localparam int TMP_W     = 16;
   // Restoring reduction by BUCKETS: BUCKETS shifted by MOD_STEPS-1 exceeds FOLD_MOD / 2.
   localparam int MOD_STEPS = 8;
   localparam logic [7:0] PAD_BYTE = 8'h20;

   localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
   localparam logic [ACT_W-1:0] ACT_SEARCH = 2'd1;
   localparam logic [ACT_W-1:0] ACT_MODIFY = 2'd2;
   localparam logic [ACT_W-1:0] ACT_DELETE = 2'd3;

   localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
   localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [STAT_W-1:0] ST_FULL      = 2'd2;

   typedef struct packed {
      logic             start;
      logic [KEY_W-1:0] key;
   } hash_req_type;

   typedef struct packed {
      logic             done;
      logic [BKT_W-1:0] bucket;
   } hash_res_type;

endpackage

`default_nettype wire

// ----- rtl/bhrt_req_if.sv -----
// Request channel of the bucketed hash record table.
`default_nettype none

interface bhrt_req_if;
   import bhrt_pkg::*;

   logic              valid;
   logic              ready;
   logic [ACT_W-1:0]  action;
   logic [KH_W-1:0]   key_high;
   logic [KL_W-1:0]   key_low;
   logic [KH_W-1:0]   new_key_high;
   logic [KL_W-1:0]   new_key_low;
   logic [PAY_W-1:0]  payload;

   modport source (
      output valid, action, key_high, key_low, new_key_high, new_key_low, payload,
      input  ready
   );
   modport sink (
      input  valid, action, key_high, key_low, new_key_high, new_key_low, payload,
      output ready
   );
endinterface

`default_nettype wire

// ----- rtl/bhrt_rsp_if.sv -----
// Response channel of the bucketed hash record table.
`default_nettype none

interface bhrt_rsp_if;
   import bhrt_pkg::*;

   logic              valid;
   logic              ready;
   logic [STAT_W-1:0] status;
   logic [PAY_W-1:0]  record_data;
   logic [BKT_W-1:0]  bucket_index;

   modport source (output valid, status, record_data, bucket_index, input ready);
   modport sink   (input  valid, status, record_data, bucket_index, output ready);
endinterface

`default_nettype wire

// ----- rtl/bucketed_hash_record_table.sv -----
// Bucketed hash record table: top level with the operation sequencer and the slot scan.
// Each request is hashed, its bucket scanned and a decision taken before the response; a
// modify that hits also hashes its new key and, when the record moves, scans the new bucket
// and moves it there; an empty key skips the scan. Requests are served one at a time through
// the shared hash unit and record memory; the next is taken once the response is taken.
// After reset a clearing pass empties every one of the BUCKETS*SLOTS slots; no request is
// taken meanwhile.
`default_nettype none

module bucketed_hash_record_table (
   input  wire logic clock,
   input  wire logic reset,
   bhrt_req_if.sink  req_chan,
   bhrt_rsp_if.source rsp_chan
);
   import bhrt_pkg::*;

   localparam logic [3:0] S_CLEAR = 4'd0;
   localparam logic [3:0] S_IDLE  = 4'd1;
   localparam logic [3:0] S_HASH1 = 4'd2;
   localparam logic [3:0] S_SCAN1 = 4'd3;
   localparam logic [3:0] S_DEC1  = 4'd4;
   localparam logic [3:0] S_HASH2 = 4'd5;
   localparam logic [3:0] S_SCAN2 = 4'd6;
   localparam logic [3:0] S_DEC2  = 4'd7;
   localparam logic [3:0] S_MOVE  = 4'd8;
   localparam logic [3:0] S_RESP  = 4'd9;

   logic [3:0]        state_ff, state_in;
   logic [ADDR_W-1:0] clr_cnt_ff, clr_cnt_in;
   logic [ACT_W-1:0]  act_ff, act_in;
   logic [KEY_W-1:0]  key_ff, key_in;
   logic [KEY_W-1:0]  nkey_ff, nkey_in;
   logic [PAY_W-1:0]  pay_ff, pay_in;
   logic [BKT_W-1:0]  bkt_ff, bkt_in;
   logic [BKT_W-1:0]  nbkt_ff, nbkt_in;
   logic [SCNT_W-1:0] iss_ff, iss_in;
   logic              chk_vld_ff, chk_vld_in;
   logic [SLOT_W-1:0] chk_slot_ff, chk_slot_in;
   logic              hit_ff, hit_in;
   logic [SLOT_W-1:0] hit_slot_ff, hit_slot_in;
   logic [PAY_W-1:0]  hit_pay_ff, hit_pay_in;
   logic              free_ff, free_in;
   logic [SLOT_W-1:0] free_slot_ff, free_slot_in;
   logic [STAT_W-1:0] status_ff, status_in;
   logic [PAY_W-1:0]  data_ff, data_in;

   logic              accept;
   logic              scanning;
   logic              go_hash2;
   logic [ADDR_W-1:0] base1;
   logic [ADDR_W-1:0] base2;
   logic [ADDR_W-1:0] scan_base;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [ENTRY_W-1:0] wr_data;
   logic [ADDR_W-1:0] rd_addr;
   logic [ENTRY_W-1:0] rd_data;
   logic [KEY_W-1:0]  ent_key;
   logic              ent_used;
   logic [KEY_W-1:0]  req_key;
   logic [KEY_W-1:0]  req_nkey;
   hash_req_type      hash_req;
   hash_res_type      hash_res;

   // A key ends at its first zero byte; everything after it reads as zero.
   function automatic logic [KEY_W-1:0] canon_key(input logic [KH_W-1:0] hi,
                                                  input logic [KL_W-1:0] lo);
      logic [KEY_W-1:0] res;
      logic             ended;
      res   = {hi, lo};
      ended = 1'b0;
      for (int i = 0; i < KEY_BYTES; i++) begin
         if (res[KEY_W-1-8*i -: 8] == 8'd0) begin
            ended = 1'b1;
         end
         if (ended) begin
            res[KEY_W-1-8*i -: 8] = 8'd0;
         end
      end
      return res;
   endfunction

   assign req_key  = canon_key(req_chan.key_high, req_chan.key_low);
   assign req_nkey = canon_key(req_chan.new_key_high, req_chan.new_key_low);

   assign req_chan.ready = (state_ff == S_IDLE);
   assign accept         = req_chan.valid && req_chan.ready;

   assign base1     = ADDR_W'(bkt_ff) * ADDR_W'(SLOTS);
   assign base2     = ADDR_W'(nbkt_ff) * ADDR_W'(SLOTS);
   assign scanning  = (state_ff == S_SCAN1) || (state_ff == S_SCAN2);
   assign scan_base = (state_ff == S_SCAN2) ? base2 : base1;
   assign rd_addr   = scan_base + ADDR_W'(iss_ff[SLOT_W-1:0]);

   assign ent_key  = rd_data[ENTRY_W-1 -: KEY_W];
   assign ent_used = (ent_key[KEY_W-1 -: 8] != 8'd0);

   assign go_hash2 = (state_ff == S_DEC1) && (act_ff == ACT_MODIFY) && hit_ff
                     && (nkey_ff[KEY_W-1 -: 8] != 8'd0);

   assign hash_req.start = accept || go_hash2;
   assign hash_req.key   = (state_ff == S_IDLE) ? req_key : nkey_ff;

   // Record memory write port.
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = base1 + ADDR_W'(hit_slot_ff);
      wr_data = '0;
      case (state_ff)
         S_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_cnt_ff;
         end
         S_DEC1: begin
            if (act_ff == ACT_INSERT && free_ff) begin
               wr_en   = 1'b1;
               wr_addr = base1 + ADDR_W'(free_slot_ff);
               wr_data = {key_ff, pay_ff};
            end else if (act_ff == ACT_DELETE && hit_ff) begin
               wr_en = 1'b1;
            end
         end
         S_HASH2: begin
            if (hash_res.done && hash_res.bucket == bkt_ff) begin
               wr_en   = 1'b1;
               wr_data = {nkey_ff, pay_ff};
            end
         end
         S_DEC2: begin
            if (free_ff) begin
               wr_en   = 1'b1;
               wr_addr = base2 + ADDR_W'(free_slot_ff);
               wr_data = {nkey_ff, pay_ff};
            end
         end
         S_MOVE: begin
            wr_en = 1'b1;
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      clr_cnt_in   = clr_cnt_ff;
      act_in       = act_ff;
      key_in       = key_ff;
      nkey_in      = nkey_ff;
      pay_in       = pay_ff;
      bkt_in       = bkt_ff;
      nbkt_in      = nbkt_ff;
      iss_in       = iss_ff;
      chk_vld_in   = 1'b0;
      chk_slot_in  = iss_ff[SLOT_W-1:0];
      hit_in       = hit_ff;
      hit_slot_in  = hit_slot_ff;
      hit_pay_in   = hit_pay_ff;
      free_in      = free_ff;
      free_slot_in = free_slot_ff;
      status_in    = status_ff;
      data_in      = data_ff;

      // Slot scan: a read issued each cycle, its data checked in the next cycle.
      if (scanning && iss_ff < SCNT_W'(SLOTS)) begin
         chk_vld_in = 1'b1;
         iss_in     = iss_ff + 1'b1;
      end
      if (chk_vld_ff) begin
         if (state_ff == S_SCAN1 && !hit_ff && ent_used && ent_key == key_ff) begin
            hit_in      = 1'b1;
            hit_slot_in = chk_slot_ff;
            hit_pay_in  = rd_data[PAY_W-1:0];
         end
         if (!ent_used && !free_ff) begin
            free_in      = 1'b1;
            free_slot_in = chk_slot_ff;
         end
      end

      case (state_ff)
         S_CLEAR: begin
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == ADDR_W'(DEPTH - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               act_in    = req_chan.action;
               key_in    = req_key;
               nkey_in   = req_nkey;
               pay_in    = req_chan.payload;
               data_in   = '0;
               status_in = ST_OK;
               state_in  = S_HASH1;
            end
         end
         S_HASH1: begin
            if (hash_res.done) begin
               bkt_in  = hash_res.bucket;
               iss_in  = '0;
               hit_in  = 1'b0;
               free_in = 1'b0;
               if (key_ff[KEY_W-1 -: 8] == 8'd0) begin
                  status_in = ST_NOT_FOUND;
                  state_in  = S_RESP;
               end else begin
                  state_in = S_SCAN1;
               end
            end
         end
         S_SCAN1: begin
            if (chk_vld_ff && chk_slot_ff == SLOT_W'(SLOTS - 1)) begin
               state_in = S_DEC1;
            end
         end
         S_DEC1: begin
            state_in = S_RESP;
            case (act_ff)
               ACT_INSERT: begin
                  status_in = free_ff ? ST_OK : ST_FULL;
               end
               ACT_SEARCH, ACT_DELETE: begin
                  if (hit_ff) begin
                     data_in = hit_pay_ff;
                  end else begin
                     status_in = ST_NOT_FOUND;
                  end
               end
               ACT_MODIFY: begin
                  if (go_hash2) begin
                     state_in = S_HASH2;
                  end else begin
                     status_in = ST_NOT_FOUND;
                  end
               end
               default: begin
                  status_in = ST_NOT_FOUND;
               end
            endcase
         end
         S_HASH2: begin
            if (hash_res.done) begin
               nbkt_in = hash_res.bucket;
               iss_in  = '0;
               free_in = 1'b0;
               if (hash_res.bucket == bkt_ff) begin
                  state_in = S_RESP;
               end else begin
                  state_in = S_SCAN2;
               end
            end
         end
         S_SCAN2: begin
            if (chk_vld_ff && chk_slot_ff == SLOT_W'(SLOTS - 1)) begin
               state_in = S_DEC2;
            end
         end
         S_DEC2: begin
            if (free_ff) begin
               state_in = S_MOVE;
            end else begin
               status_in = ST_FULL;
               state_in  = S_RESP;
            end
         end
         S_MOVE: begin
            state_in = S_RESP;
         end
         S_RESP: begin
            if (rsp_chan.ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_CLEAR;
         clr_cnt_ff <= '0;
         chk_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         clr_cnt_ff <= clr_cnt_in;
         chk_vld_ff <= chk_vld_in;
      end
      act_ff       <= act_in;
      key_ff       <= key_in;
      nkey_ff      <= nkey_in;
      pay_ff       <= pay_in;
      bkt_ff       <= bkt_in;
      nbkt_ff      <= nbkt_in;
      iss_ff       <= iss_in;
      chk_slot_ff  <= chk_slot_in;
      hit_ff       <= hit_in;
      hit_slot_ff  <= hit_slot_in;
      hit_pay_ff   <= hit_pay_in;
      free_ff      <= free_in;
      free_slot_ff <= free_slot_in;
      status_ff    <= status_in;
      data_ff      <= data_in;
   end

   bhrt_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (DEPTH)
   ) u_bhrt_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   bhrt_hash u_bhrt_hash (
      .clock    (clock),
      .reset    (reset),
      .hash_req (hash_req),
      .hash_res (hash_res)
   );

   assign rsp_chan.valid        = (state_ff == S_RESP);
   assign rsp_chan.status       = status_ff;
   assign rsp_chan.record_data  = data_ff;
   assign rsp_chan.bucket_index = bkt_ff;
endmodule

`default_nettype wire

// ----- rtl/bhrt_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module bhrt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

`default_nettype wire

// ----- rtl/bhrt_hash.sv -----
// Iterative folding hash: one byte pair per cycle, then a restoring reduction by BUCKETS.
`default_nettype none

module bhrt_hash (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire bhrt_pkg::hash_req_type hash_req,
   output bhrt_pkg::hash_res_type     hash_res
);
   import bhrt_pkg::*;

   localparam int PAD_W = 8 * (KEY_BYTES + 1);
   localparam int CNT_W = $clog2(MOD_STEPS);

   localparam logic [1:0] HS_IDLE = 2'd0;
   localparam logic [1:0] HS_FOLD = 2'd1;
   localparam logic [1:0] HS_MOD  = 2'd2;

   logic [1:0]       state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [PAD_W-1:0] pad_ff, pad_in;
   logic [SUM_W-1:0] acc_ff, acc_in;
   logic             done_ff, done_in;

   logic [TMP_W-1:0] fold_sum;
   logic [SUM_W-1:0] fold_nxt;
   logic [TMP_W-1:0] trial;
   logic [SUM_W-1:0] mod_nxt;

   // Blank bytes after the end of the key hash as spaces, and a twelfth space follows.
   function automatic logic [PAD_W-1:0] pad_key(input logic [KEY_W-1:0] key);
      logic [PAD_W-1:0] res;
      logic [7:0]       kb;
      res = '0;
      for (int i = 0; i < KEY_BYTES; i++) begin
         kb = key[KEY_W-1-8*i -: 8];
         res[PAD_W-1-8*i -: 8] = (kb == 8'd0) ? PAD_BYTE : kb;
      end
      res[7:0] = PAD_BYTE;
      return res;
   endfunction

   always_comb begin
      fold_sum = TMP_W'(acc_ff) + TMP_W'(pad_ff[PAD_W-1 -: 8]) * TMP_W'(FOLD_MUL)
               + TMP_W'(pad_ff[PAD_W-9 -: 8]);
      if (fold_sum >= TMP_W'(2 * FOLD_MOD)) begin
         fold_nxt = SUM_W'(fold_sum - TMP_W'(2 * FOLD_MOD));
      end else if (fold_sum >= TMP_W'(FOLD_MOD)) begin
         fold_nxt = SUM_W'(fold_sum - TMP_W'(FOLD_MOD));
      end else begin
         fold_nxt = SUM_W'(fold_sum);
      end
      trial = TMP_W'(BUCKETS) << cnt_ff;
      if (TMP_W'(acc_ff) >= trial) begin
         mod_nxt = SUM_W'(TMP_W'(acc_ff) - trial);
      end else begin
         mod_nxt = acc_ff;
      end
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      pad_in   = pad_ff;
      acc_in   = acc_ff;
      done_in  = 1'b0;
      case (state_ff)
         HS_IDLE: begin
            if (hash_req.start) begin
               pad_in   = pad_key(hash_req.key);
               acc_in   = '0;
               cnt_in   = '0;
               state_in = HS_FOLD;
            end
         end
         HS_FOLD: begin
            acc_in = fold_nxt;
            pad_in = pad_ff << 16;
            if (cnt_ff == CNT_W'(PAIRS - 1)) begin
               cnt_in   = CNT_W'(MOD_STEPS - 1);
               state_in = HS_MOD;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         HS_MOD: begin
            acc_in = mod_nxt;
            if (cnt_ff == '0) begin
               done_in  = 1'b1;
               state_in = HS_IDLE;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         default: begin
            state_in = HS_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= HS_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      cnt_ff <= cnt_in;
      pad_ff <= pad_in;
      acc_ff <= acc_in;
   end

   assign hash_res.done   = done_ff;
   assign hash_res.bucket = acc_ff[BKT_W-1:0];
endmodule

`default_nettype wire

// ----- rtl/bhrt_checker.sv -----
// Port-level checks of the bucketed hash record table, bound to its top level.
`default_nettype none

module bhrt_checker (
   input wire logic                        clock,
   input wire logic                        reset,
   input wire logic                        req_valid,
   input wire logic                        req_ready,
   input wire logic                        rsp_valid,
   input wire logic                        rsp_ready,
   input wire logic [bhrt_pkg::STAT_W-1:0] rsp_status,
   input wire logic [bhrt_pkg::PAY_W-1:0]  rsp_record_data,
   input wire logic [bhrt_pkg::BKT_W-1:0]  rsp_bucket_index
);
   import bhrt_pkg::*;

   // A stalled response keeps its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_record_data) && $stable(rsp_bucket_index))
      else $error("response changed while stalled");

   // Only one request is in flight: no new request is taken while a response waits.
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("request taken while a response is pending");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("block ready again straight after taking a request");

   a_rsp_codes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_bucket_index < BKT_W'(BUCKETS))
         && (rsp_status == ST_OK || rsp_status == ST_NOT_FOUND || rsp_status == ST_FULL))
      else $error("response carries an impossible bucket or status");

   a_fail_no_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> rsp_record_data == '0)
      else $error("failed request returned record data");
endmodule

bind bucketed_hash_record_table bhrt_checker u_bhrt_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_chan.valid),
   .req_ready        (req_chan.ready),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .rsp_status       (rsp_chan.status),
   .rsp_record_data  (rsp_chan.record_data),
   .rsp_bucket_index (rsp_chan.bucket_index)
);

`default_nettype wire

// ----- verif/bhrt_tb_pkg.sv -----
// Scoreboard for the bucketed hash record table: a record-level predictor and the response check.
`timescale 1ns / 1ps

package bhrt_tb_pkg;
   import bhrt_pkg::*;

   typedef struct {
      logic [STAT_W-1:0] status;
      logic [PAY_W-1:0]  data;
      logic [BKT_W-1:0]  bucket;
   } table_answer_type;

   class record_table_scoreboard;
      logic [KEY_W-1:0] slot_key [DEPTH];
      logic [PAY_W-1:0] slot_pay [DEPTH];
      int unsigned      fill [BUCKETS];
      table_answer_type answers_due [$];
      int unsigned      mismatches;

      function new();
         foreach (slot_key[i]) begin
            slot_key[i] = '0;
            slot_pay[i] = '0;
         end
         foreach (fill[i]) fill[i] = 0;
         mismatches = 0;
      endfunction

      // A key ends at its first zero byte; whatever follows is read as zero.
      static function logic [KEY_W-1:0] trim_key(logic [KEY_W-1:0] raw);
         logic [KEY_W-1:0] k;
         bit               ended;
         k     = raw;
         ended = 1'b0;
         for (int i = 0; i < KEY_BYTES; i++) begin
            if (k[KEY_W-1-8*i -: 8] == 8'h00) ended = 1'b1;
            if (ended) k[KEY_W-1-8*i -: 8] = 8'h00;
         end
         return k;
      endfunction

      static function int unsigned bucket_of(logic [KEY_W-1:0] raw);
         logic [KEY_W-1:0] k;
         logic [7:0]       padded [KEY_BYTES+1];
         int unsigned      sum;
         k = trim_key(raw);
         for (int i = 0; i < KEY_BYTES; i++)
            padded[i] = (k[KEY_W-1-8*i -: 8] == 8'h00) ? PAD_BYTE : k[KEY_W-1-8*i -: 8];
         padded[KEY_BYTES] = PAD_BYTE;
         sum = 0;
         for (int i = 0; i < KEY_BYTES + 1; i += 2)
            sum = (sum + FOLD_MUL * padded[i] + padded[i+1]) % FOLD_MOD;
         return sum % BUCKETS;
      endfunction

      function int find_slot(int unsigned b, logic [KEY_W-1:0] k);
         int unsigned x;
         for (int s = 0; s < SLOTS; s++) begin
            x = b * SLOTS + s;
            if (slot_key[x][KEY_W-1 -: 8] != 8'h00 && slot_key[x] == k) return s;
         end
         return -1;
      endfunction

      function bit place(int unsigned b, logic [KEY_W-1:0] k, logic [PAY_W-1:0] pay);
         int unsigned x;
         if (fill[b] >= SLOTS) return 1'b0;
         for (int s = 0; s < SLOTS; s++) begin
            x = b * SLOTS + s;
            if (slot_key[x][KEY_W-1 -: 8] == 8'h00) begin
               slot_key[x] = k;
               slot_pay[x] = pay;
               fill[b]++;
               return 1'b1;
            end
         end
         return 1'b0;
      endfunction

      function void clear_slot(int unsigned b, int s);
         slot_key[b * SLOTS + s] = '0;
         slot_pay[b * SLOTS + s] = '0;
         if (fill[b] > 0) fill[b]--;
      endfunction

      // Applies one accepted request to the table copy and queues the answer it must give.
      function void note_request(logic [ACT_W-1:0] action, logic [KEY_W-1:0] key_raw,
                                 logic [KEY_W-1:0] new_raw, logic [PAY_W-1:0] pay);
         logic [KEY_W-1:0] k, nk;
         int unsigned      b, nb;
         int               s;
         table_answer_type ans;
         k          = trim_key(key_raw);
         b          = bucket_of(k);
         ans.status = ST_OK;
         ans.data   = '0;
         ans.bucket = BKT_W'(b);
         if (k[KEY_W-1 -: 8] == 8'h00) begin
            ans.status = ST_NOT_FOUND;
         end else if (action == ACT_INSERT) begin
            if (!place(b, k, pay)) ans.status = ST_FULL;
         end else begin
            s = find_slot(b, k);
            if (s < 0) begin
               ans.status = ST_NOT_FOUND;
            end else if (action == ACT_SEARCH) begin
               ans.data = slot_pay[b * SLOTS + s];
            end else if (action == ACT_DELETE) begin
               ans.data = slot_pay[b * SLOTS + s];
               clear_slot(b, s);
            end else begin
               nk = trim_key(new_raw);
               nb = bucket_of(nk);
               if (nk[KEY_W-1 -: 8] == 8'h00) begin
                  ans.status = ST_NOT_FOUND;
               end else if (nb == b) begin
                  // The record stays in its bucket, so it is rewritten where it lies.
                  slot_key[b * SLOTS + s] = nk;
                  slot_pay[b * SLOTS + s] = pay;
               end else if (fill[nb] >= SLOTS) begin
                  ans.status = ST_FULL;
               end else begin
                  clear_slot(b, s);
                  void'(place(nb, nk, pay));
               end
            end
         end
         answers_due.push_back(ans);
      endfunction

      task report_mismatch(string what);
         $display("MISMATCH at %0t: %s", $time, what);
         mismatches++;
      endtask

      task check_response(logic [STAT_W-1:0] status, logic [PAY_W-1:0] data,
                          logic [BKT_W-1:0] bucket);
         table_answer_type want;
         if (answers_due.size() == 0) begin
            report_mismatch("response with no request outstanding");
         end else begin
            want = answers_due.pop_front();
            if (status !== want.status)
               report_mismatch($sformatf("status %0d, expected %0d", status, want.status));
            if (data !== want.data)
               report_mismatch($sformatf("record_data %h, expected %h", data, want.data));
            if (bucket !== want.bucket)
               report_mismatch($sformatf("bucket_index %0d, expected %0d", bucket, want.bucket));
         end
      endtask

      function int outstanding();
         return answers_due.size();
      endfunction
   endclass

endpackage

// ----- verif/tb_top.sv -----
// Top-level testbench of the bucketed hash record table: stimulus, handshakes and final verdict.
`timescale 1ns / 1ps

module tb_top;
   import bhrt_pkg::*;
   import bhrt_tb_pkg::*;

   localparam int PHASE_ITEMS = 250;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   int unsigned send_idle_pct = 38;
   int unsigned recv_idle_pct = 68;

   bhrt_req_if req_if ();
   bhrt_rsp_if rsp_if ();

   record_table_scoreboard table_sb;
   logic [KEY_W-1:0]       key_pool [$];
   int unsigned            hot_bucket [4];

   bucketed_hash_record_table i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if.sink),
      .rsp_chan (rsp_if.source)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   initial begin
      #5_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   always @(negedge clock) begin
      rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready)
         table_sb.check_response(rsp_if.status, rsp_if.record_data, rsp_if.bucket_index);
   end

   function automatic logic [KEY_W-1:0] random_key();
      logic [KEY_W-1:0] k;
      int unsigned      len;
      bit               garbage;
      k       = '0;
      len     = $urandom_range(KEY_BYTES, 1);
      garbage = $urandom_range(1);
      for (int i = 0; i < KEY_BYTES; i++) begin
         if (i < len)
            k[KEY_W-1-8*i -: 8] = ($urandom_range(7) == 0) ? 8'($urandom_range(255, 1))
                                                          : 8'($urandom_range(8'h7e, 8'h21));
         else if (i > len && garbage)
            k[KEY_W-1-8*i -: 8] = 8'($urandom);
      end
      return k;
   endfunction

   function automatic logic [KEY_W-1:0] empty_key();
      logic [KEY_W-1:0] k;
      k = KEY_W'({$urandom, $urandom, $urandom});
      k[KEY_W-1 -: 8] = 8'h00;
      return k;
   endfunction

   function automatic logic [KEY_W-1:0] key_in_bucket(int unsigned b);
      logic [KEY_W-1:0] k;
      do k = random_key(); while (record_table_scoreboard::bucket_of(k) != b);
      return k;
   endfunction

   function automatic logic [KEY_W-1:0] key_outside_bucket(int unsigned b);
      logic [KEY_W-1:0] k;
      do k = random_key(); while (record_table_scoreboard::bucket_of(k) == b);
      return k;
   endfunction

   // Reuses a known key with fresh junk after its terminator, which must be ignored.
   function automatic logic [KEY_W-1:0] pick_pool_key();
      logic [KEY_W-1:0] k;
      bit               ended;
      if (key_pool.size() == 0) return random_key();
      k     = record_table_scoreboard::trim_key(key_pool[$urandom_range(key_pool.size() - 1)]);
      ended = 1'b0;
      for (int i = 0; i < KEY_BYTES; i++) begin
         if (ended) begin
            if ($urandom_range(1)) k[KEY_W-1-8*i -: 8] = 8'($urandom);
         end else if (k[KEY_W-1-8*i -: 8] == 8'h00) begin
            ended = 1'b1;
         end
      end
      return k;
   endfunction

   function automatic void remember_key(logic [KEY_W-1:0] k);
      if (key_pool.size() < 48) key_pool.push_back(k);
      else key_pool[$urandom_range(key_pool.size() - 1)] = k;
   endfunction

   task automatic send_request(logic [ACT_W-1:0] act, logic [KEY_W-1:0] key,
                               logic [KEY_W-1:0] new_key, logic [PAY_W-1:0] pay);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid        <= 1'b1;
      req_if.action       <= act;
      req_if.key_high     <= key[KEY_W-1 -: KH_W];
      req_if.key_low      <= key[KL_W-1:0];
      req_if.new_key_high <= new_key[KEY_W-1 -: KH_W];
      req_if.new_key_low  <= new_key[KL_W-1:0];
      req_if.payload      <= pay;
      do @(posedge clock); while (!req_if.ready);
      table_sb.note_request(act, key, new_key, pay);
   endtask

   // Holds the sender off until every outstanding request has been answered.
   task automatic drain_table();
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (table_sb.outstanding() != 0) @(posedge clock);
   endtask

   task automatic run_directed();
      logic [KEY_W-1:0] ones_key, ab_key, moved_key, k;
      int unsigned      b;
      ones_key = '1;
      k        = empty_key();
      send_request(ACT_INSERT, k, '0, '1);
      send_request(ACT_SEARCH, k, '0, '0);
      send_request(ACT_MODIFY, k, ones_key, '1);
      send_request(ACT_DELETE, k, '0, '0);
      // Duplicates are allowed; search and delete act on the lower slot first.
      send_request(ACT_INSERT, ones_key, '0, '1);
      send_request(ACT_INSERT, ones_key, '0, '0);
      send_request(ACT_SEARCH, ones_key, '0, '0);
      b = record_table_scoreboard::bucket_of(ones_key);
      send_request(ACT_INSERT, key_in_bucket(b), '0, 64'h0000_0000_0000_0001);
      send_request(ACT_INSERT, key_in_bucket(b), '0, 64'h8000_0000_0000_0000);
      send_request(ACT_INSERT, key_in_bucket(b), '0, 64'h5a5a_5a5a_5a5a_5a5a);
      // A short key with junk after its end, looked up with zeros after its end.
      ab_key = {8'h41, 8'h42, 8'h00, 64'hdead_beef_0123_4567};
      send_request(ACT_INSERT, ab_key, '0, 64'h0123_4567_89ab_cdef);
      send_request(ACT_SEARCH, {8'h41, 8'h42, 8'h00, 64'h0}, '0, '0);
      send_request(ACT_MODIFY, ab_key, key_in_bucket(b), '1);
      moved_key = key_in_bucket(record_table_scoreboard::bucket_of(ab_key));
      send_request(ACT_MODIFY, ab_key, moved_key, 64'hfedc_ba98_7654_3210);
      k = key_outside_bucket(record_table_scoreboard::bucket_of(moved_key));
      send_request(ACT_MODIFY, moved_key, k, 64'h1111_2222_3333_4444);
      send_request(ACT_SEARCH, k, '0, '0);
      send_request(ACT_MODIFY, k, empty_key(), '0);
      send_request(ACT_MODIFY, random_key(), random_key(), '1);
      send_request(ACT_DELETE, ones_key, '0, '0);
      send_request(ACT_DELETE, ones_key, '0, '0);
      send_request(ACT_DELETE, ones_key, '0, '0);
      send_request(ACT_SEARCH, random_key(), '0, '0);
   endtask

   // Mostly requests on known keys and keys aimed at a few crowded buckets, plus raw noise.
   task automatic random_request();
      logic [ACT_W-1:0] act;
      logic [KEY_W-1:0] key, new_key;
      logic [PAY_W-1:0] pay;
      int unsigned      pick;
      pay  = {$urandom, $urandom};
      pick = $urandom_range(9);
      if (pick == 0) pay = '0;
      else if (pick == 1) pay = '1;
      new_key = KEY_W'({$urandom, $urandom, $urandom});
      if ($urandom_range(99) < 10) begin
         act = ACT_W'($urandom);
         key = KEY_W'({$urandom, $urandom, $urandom});
      end else begin
         pick = $urandom_range(99);
         if (pick < 35) act = ACT_INSERT;
         else if (pick < 60) act = ACT_SEARCH;
         else if (pick < 80) act = ACT_MODIFY;
         else act = ACT_DELETE;
         pick = $urandom_range(99);
         if (act == ACT_INSERT) begin
            if (pick < 60) key = key_in_bucket(hot_bucket[$urandom_range(3)]);
            else if (pick < 85) key = random_key();
            else key = pick_pool_key();
            remember_key(key);
         end else begin
            if (pick < 75) key = pick_pool_key();
            else if (pick < 95) key = random_key();
            else key = empty_key();
         end
         if (act == ACT_MODIFY) begin
            pick = $urandom_range(99);
            if (pick < 15) new_key = key_in_bucket(record_table_scoreboard::bucket_of(key));
            else if (pick < 55) new_key = key_in_bucket(hot_bucket[$urandom_range(3)]);
            else if (pick < 80) new_key = random_key();
            else if (pick < 90) new_key = pick_pool_key();
            else new_key = empty_key();
            remember_key(new_key);
         end
      end
      send_request(act, key, new_key, pay);
   endtask

   initial begin
      table_sb            = new();
      req_if.valid        = 1'b0;
      req_if.action       = ACT_INSERT;
      req_if.key_high     = '0;
      req_if.key_low      = '0;
      req_if.new_key_high = '0;
      req_if.new_key_low  = '0;
      req_if.payload      = '0;
      rsp_if.ready        = 1'b0;
      foreach (hot_bucket[i]) hot_bucket[i] = $urandom_range(BUCKETS - 1);
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      run_directed();
      drain_table();
      repeat (PHASE_ITEMS) random_request();
      drain_table();
      send_idle_pct = 68;
      recv_idle_pct = 38;
      repeat (PHASE_ITEMS) random_request();
      drain_table();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      repeat (PHASE_ITEMS) random_request();
      drain_table();
      repeat (60) @(posedge clock);

      if (table_sb.mismatches == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/bhrt_pkg.sv
rtl/bhrt_req_if.sv
rtl/bhrt_rsp_if.sv
rtl/bhrt_ram.sv
rtl/bhrt_hash.sv
rtl/bucketed_hash_record_table.sv
rtl/bhrt_checker.sv
verif/bhrt_tb_pkg.sv
verif/tb_top.sv
